@@ sv/vprf_pkg.sv @@
// Shared constants, types and helper functions of the variable-length packet ring FIFO.
package vprf_pkg;

    localparam int RING_WORDS        = 1024;
    localparam int PTR_W             = $clog2(RING_WORDS);
    localparam int HEADER_WORDS      = 8;
    localparam int MAX_PAYLOAD_WORDS = 63;
    localparam int NW_W              = $clog2(MAX_PAYLOAD_WORDS + 1);
    localparam int USER_WORDS        = 4;
    // Header words that carry information: length, sequence number and user words.
    localparam int HDR_READS         = 2 + USER_WORDS;
    localparam int HDR_IDX_W         = $clog2(HEADER_WORDS + 1);
    localparam int IDX_W             = (NW_W > HDR_IDX_W) ? NW_W : HDR_IDX_W;

    localparam int KIND_W = 3;
    localparam int LEN_W  = 8;
    localparam int WORD_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_HDR  = 3'd0,
        KIND_PUSH_DATA = 3'd1,
        KIND_GET       = 3'd2,
        KIND_PEEK      = 3'd3,
        KIND_CLEAR     = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHDR,
        S_PTAIL,
        S_GHDR,
        S_GCHK,
        S_GHL,
        S_GHEAD,
        S_GWORD,
        S_EMIT
    } state_t;

    typedef logic [USER_WORDS-1:0][WORD_W-1:0] user_vec_t;

    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
    } ram_rd_t;

    // Content of one header word: length, sequence number, user words, then zeros.
    function automatic logic [WORD_W-1:0] hdr_word(input logic [IDX_W-1:0]  idx,
                                                   input logic [LEN_W-1:0]  len,
                                                   input logic [WORD_W-1:0] seq,
                                                   input user_vec_t         users);
        logic [WORD_W-1:0] w;
        w = '0;
        if (idx == IDX_W'(0)) begin
            w = WORD_W'(len);
        end
        else if (idx == IDX_W'(1)) begin
            w = seq;
        end
        else begin
            for (int u = 0; u < USER_WORDS; u++) begin
                if (idx == IDX_W'(2 + u)) begin
                    w = users[u];
                end
            end
        end
        return w;
    endfunction

    // Keeps the valid bytes of the final payload word.
    function automatic logic [WORD_W-1:0] tail_mask(input logic [1:0] tail_bytes);
        logic [WORD_W-1:0] m;
        case (tail_bytes)
            2'd1:    m = 32'h0000_00FF;
            2'd2:    m = 32'h0000_FFFF;
            2'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

@@ sv/vprf_in_if.sv @@
// Request channel of the packet ring FIFO: valid, ready and one request item.
interface vprf_in_if;
    logic                          valid;
    logic                          ready;
    logic [vprf_pkg::KIND_W-1:0]   kind;
    logic [vprf_pkg::LEN_W-1:0]    data_len;
    logic [vprf_pkg::WORD_W-1:0]   user_word1;
    logic [vprf_pkg::WORD_W-1:0]   user_word2;
    logic [vprf_pkg::WORD_W-1:0]   user_word3;
    logic [vprf_pkg::WORD_W-1:0]   user_word4;
    logic [vprf_pkg::WORD_W-1:0]   payload_word;
    logic [vprf_pkg::LEN_W-1:0]    buffer_size;
    logic                          header_only;

    modport source (
        output valid, kind, data_len, user_word1, user_word2, user_word3, user_word4,
               payload_word, buffer_size, header_only,
        input  ready
    );

    modport sink (
        input  valid, kind, data_len, user_word1, user_word2, user_word3, user_word4,
               payload_word, buffer_size, header_only,
        output ready
    );
endinterface

@@ sv/vprf_out_if.sv @@
// Response channel of the packet ring FIFO: valid, ready and one result item.
interface vprf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [vprf_pkg::LEN_W-1:0]    packet_len;
    logic [vprf_pkg::WORD_W-1:0]   seq_number;
    logic [vprf_pkg::WORD_W-1:0]   out_user1;
    logic [vprf_pkg::WORD_W-1:0]   out_user2;
    logic [vprf_pkg::WORD_W-1:0]   out_user3;
    logic [vprf_pkg::WORD_W-1:0]   out_user4;
    logic [vprf_pkg::WORD_W-1:0]   out_word;
    logic                          last;
    logic [vprf_pkg::LEN_W-1:0]    head_len;
    logic                          empty_res;

    modport source (
        output valid, ok, packet_len, seq_number, out_user1, out_user2, out_user3,
               out_user4, out_word, last, head_len, empty_res,
        input  ready
    );

    modport sink (
        input  valid, ok, packet_len, seq_number, out_user1, out_user2, out_user3,
               out_user4, out_word, last, head_len, empty_res,
        output ready
    );
endinterface

@@ sv/vprf_ring_ram.sv @@
// Word store of the packet ring: one write port and one registered read port.
module vprf_ring_ram (
    input  logic                        clk,
    input  vprf_pkg::ram_wr_t           wr,
    input  vprf_pkg::ram_rd_t           rd,
    output logic [vprf_pkg::WORD_W-1:0] rd_data
);

    logic [vprf_pkg::WORD_W-1:0] mem [vprf_pkg::RING_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // The read data holds until the next read, so a stalled consumer sees a steady word.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ sv/variable_packet_ring_fifo.sv @@
// Top level of the variable-length packet ring FIFO: sequencer, pointers and result register.
//
// Usage: requests arrive on req (push header, push data word, get, peek, clear) and results
// leave on rsp. Every request yields one result, except a successful get or peek, which
// yields a header result followed by one result per payload word (none with header_only);
// the final result of a request has last set. All packets live in a 1024-word single-write,
// single-read memory. Steps per request:
//   push header: the header words are written, then the tail word of an empty packet,
//     then the result is loaded;
//   push data word: the word is written at acceptance, the final word adds a tail write;
//   get/peek: 6 header reads, a length check and, for get, one read of the next head when
//     another packet follows, then the header result and one payload word per cycle.
// The payload rate holds while rsp does not stall. One request is worked on at a time,
// and a new one is taken while the previous final result still waits in rsp.
// When the receiver stalls, the result register holds and the sequencer waits with it.
// Reset empties the ring and clears the sequence counter; the memory itself is not cleared,
// since only committed packets are ever read back.
module variable_packet_ring_fifo (
    input  logic          clk,
    input  logic          rst_n,
    vprf_in_if.sink       req,
    vprf_out_if.source    rsp
);

    vprf_pkg::state_t state_reg, state_next;

    // Ring state.
    logic [vprf_pkg::PTR_W-1:0]  rp_reg, rp_next;
    logic [vprf_pkg::PTR_W-1:0]  wp_reg, wp_next;
    logic [vprf_pkg::PTR_W-1:0]  cursor_reg, cursor_next;
    logic [vprf_pkg::NW_W-1:0]   left_reg, left_next;
    logic                        active_reg, active_next;
    logic [vprf_pkg::WORD_W-1:0] seq_cnt_reg, seq_cnt_next;
    logic [vprf_pkg::LEN_W-1:0]  head_len_reg, head_len_next;
    logic [vprf_pkg::LEN_W-1:0]  push_len_reg, push_len_next;

    // Working registers of the request in progress.
    logic [vprf_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [vprf_pkg::WORD_W-1:0] seq_reg, seq_next;
    vprf_pkg::user_vec_t         user_reg, user_next;
    logic                        ok_reg, ok_next;
    logic                        show_reg, show_next;
    logic                        consume_reg, consume_next;
    logic                        hdr_only_reg, hdr_only_next;
    logic [vprf_pkg::LEN_W-1:0]  bsize_reg, bsize_next;
    logic [vprf_pkg::NW_W-1:0]   nw_reg, nw_next;
    logic [vprf_pkg::PTR_W-1:0]  new_rp_reg, new_rp_next;
    logic [vprf_pkg::LEN_W-1:0]  hl_after_reg, hl_after_next;
    logic                        empty_after_reg, empty_after_next;
    logic [vprf_pkg::IDX_W-1:0]  idx_reg, idx_next;

    // Result register.
    logic                        out_valid_reg;
    logic                        o_ok_reg;
    logic [vprf_pkg::LEN_W-1:0]  o_len_reg;
    logic [vprf_pkg::WORD_W-1:0] o_seq_reg;
    vprf_pkg::user_vec_t         o_user_reg;
    logic [vprf_pkg::WORD_W-1:0] o_word_reg;
    logic                        o_last_reg;
    logic [vprf_pkg::LEN_W-1:0]  o_hl_reg;
    logic                        o_empty_reg;

    logic                        emit;
    logic                        e_ok;
    logic [vprf_pkg::LEN_W-1:0]  e_len;
    logic [vprf_pkg::WORD_W-1:0] e_seq;
    vprf_pkg::user_vec_t         e_user;
    logic [vprf_pkg::WORD_W-1:0] e_word;
    logic                        e_last;
    logic [vprf_pkg::LEN_W-1:0]  e_hl;
    logic                        e_empty;

    vprf_pkg::ram_wr_t           ram_wr;
    vprf_pkg::ram_rd_t           ram_rd;
    logic [vprf_pkg::WORD_W-1:0] ram_rd_data;

    // Shared conditions.
    logic                         fire;
    logic                         slot_free;
    logic                         ring_empty;
    logic [vprf_pkg::NW_W:0]      push_nw;
    logic [vprf_pkg::PTR_W-1:0]   used_words;
    logic [vprf_pkg::PTR_W:0]     free_words;
    logic [vprf_pkg::PTR_W:0]     total_words;
    logic                         push_ok;
    logic [vprf_pkg::NW_W:0]      get_nw_full;
    logic [vprf_pkg::NW_W-1:0]    get_nw;
    logic                         get_fail;
    logic [vprf_pkg::PTR_W-1:0]   new_rp;
    logic                         head_last;
    logic                         word_last;
    vprf_pkg::user_vec_t          req_users;

    vprf_ring_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    assign req.ready  = (state_reg == vprf_pkg::S_IDLE);
    assign fire       = req.valid && req.ready;
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign ring_empty = (rp_reg == wp_reg);

    assign req_users = {req.user_word4, req.user_word3, req.user_word2, req.user_word1};

    // Space check for a new packet: header, payload words and tail must leave one word free.
    assign push_nw     = (vprf_pkg::NW_W + 1)'((9'(req.data_len) + 9'd3) >> 2);
    assign used_words  = wp_reg - rp_reg;
    assign free_words  = (vprf_pkg::PTR_W + 1)'(vprf_pkg::RING_WORDS) - {1'b0, used_words};
    assign total_words = (vprf_pkg::PTR_W + 1)'(vprf_pkg::HEADER_WORDS + 1)
                       + (vprf_pkg::PTR_W + 1)'(push_nw);
    assign push_ok     = (push_nw <= (vprf_pkg::NW_W + 1)'(vprf_pkg::MAX_PAYLOAD_WORDS))
                      && (free_words > total_words);

    assign get_nw_full = (vprf_pkg::NW_W + 1)'((9'(len_reg) + 9'd3) >> 2);
    assign get_nw      = (get_nw_full > (vprf_pkg::NW_W + 1)'(vprf_pkg::MAX_PAYLOAD_WORDS))
                       ? vprf_pkg::NW_W'(vprf_pkg::MAX_PAYLOAD_WORDS)
                       : get_nw_full[vprf_pkg::NW_W-1:0];
    assign get_fail    = !hdr_only_reg && (len_reg != '0) && (len_reg > bsize_reg);
    assign new_rp      = rp_reg + vprf_pkg::PTR_W'(vprf_pkg::HEADER_WORDS + 1)
                       + vprf_pkg::PTR_W'(get_nw);
    assign head_last   = hdr_only_reg || (nw_reg == '0);
    assign word_last   = ((idx_reg + 1'b1) == vprf_pkg::IDX_W'(nw_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vprf_pkg::S_IDLE:
            begin
                if (fire)
                begin
                    unique case (vprf_pkg::kind_t'(req.kind))
                        vprf_pkg::KIND_PUSH_HDR:
                            state_next = push_ok ? vprf_pkg::S_PHDR : vprf_pkg::S_EMIT;
                        vprf_pkg::KIND_PUSH_DATA:
                            state_next = (active_reg && left_reg == vprf_pkg::NW_W'(1))
                                       ? vprf_pkg::S_PTAIL : vprf_pkg::S_EMIT;
                        vprf_pkg::KIND_GET, vprf_pkg::KIND_PEEK:
                            state_next = ring_empty ? vprf_pkg::S_EMIT : vprf_pkg::S_GHDR;
                        default:
                            state_next = vprf_pkg::S_EMIT;
                    endcase
                end
            end
            vprf_pkg::S_PHDR:
            begin
                if (idx_reg == vprf_pkg::IDX_W'(vprf_pkg::HEADER_WORDS - 1))
                begin
                    state_next = (left_reg == '0) ? vprf_pkg::S_PTAIL : vprf_pkg::S_EMIT;
                end
            end
            vprf_pkg::S_PTAIL:
                state_next = vprf_pkg::S_EMIT;
            vprf_pkg::S_GHDR:
            begin
                if (idx_reg == vprf_pkg::IDX_W'(vprf_pkg::HDR_READS))
                begin
                    state_next = vprf_pkg::S_GCHK;
                end
            end
            vprf_pkg::S_GCHK:
            begin
                if (get_fail)
                begin
                    state_next = vprf_pkg::S_EMIT;
                end
                else if (consume_reg && new_rp != wp_reg)
                begin
                    state_next = vprf_pkg::S_GHL;
                end
                else
                begin
                    state_next = vprf_pkg::S_GHEAD;
                end
            end
            vprf_pkg::S_GHL:
                state_next = vprf_pkg::S_GHEAD;
            vprf_pkg::S_GHEAD:
            begin
                if (slot_free)
                begin
                    state_next = head_last ? vprf_pkg::S_IDLE : vprf_pkg::S_GWORD;
                end
            end
            vprf_pkg::S_GWORD:
            begin
                if (slot_free && word_last)
                begin
                    state_next = vprf_pkg::S_IDLE;
                end
            end
            vprf_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = vprf_pkg::S_IDLE;
                end
            end
            default:
                state_next = vprf_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory accesses and result loading.
    always_comb
    begin
        rp_next          = rp_reg;
        wp_next          = wp_reg;
        cursor_next      = cursor_reg;
        left_next        = left_reg;
        active_next      = active_reg;
        seq_cnt_next     = seq_cnt_reg;
        head_len_next    = head_len_reg;
        push_len_next    = push_len_reg;
        len_next         = len_reg;
        seq_next         = seq_reg;
        user_next        = user_reg;
        ok_next          = ok_reg;
        show_next        = show_reg;
        consume_next     = consume_reg;
        hdr_only_next    = hdr_only_reg;
        bsize_next       = bsize_reg;
        nw_next          = nw_reg;
        new_rp_next      = new_rp_reg;
        hl_after_next    = hl_after_reg;
        empty_after_next = empty_after_reg;
        idx_next         = idx_reg;

        ram_wr  = '0;
        ram_rd  = '0;
        emit    = 1'b0;
        e_ok    = 1'b0;
        e_len   = '0;
        e_seq   = '0;
        e_user  = '0;
        e_word  = '0;
        e_last  = 1'b0;
        e_hl    = '0;
        e_empty = 1'b0;

        unique case (state_reg)
            vprf_pkg::S_IDLE:
            begin
                if (fire)
                begin
                    show_next = 1'b0;
                    ok_next   = 1'b0;
                    idx_next  = '0;
                    unique case (vprf_pkg::kind_t'(req.kind))
                        vprf_pkg::KIND_PUSH_HDR:
                        begin
                            // Any unfinished packet is dropped; the counter advances anyway.
                            seq_cnt_next = seq_cnt_reg + 1'b1;
                            active_next  = 1'b0;
                            left_next    = '0;
                            ok_next      = push_ok;
                            show_next    = 1'b1;
                            len_next     = req.data_len;
                            seq_next     = seq_cnt_reg;
                            user_next    = req_users;
                            if (push_ok)
                            begin
                                push_len_next = req.data_len;
                                cursor_next   = wp_reg + vprf_pkg::PTR_W'(vprf_pkg::HEADER_WORDS);
                                left_next     = push_nw[vprf_pkg::NW_W-1:0];
                            end
                        end
                        vprf_pkg::KIND_PUSH_DATA:
                        begin
                            if (active_reg)
                            begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = cursor_reg;
                                ram_wr.data = req.payload_word;
                                cursor_next = cursor_reg + 1'b1;
                                left_next   = left_reg - 1'b1;
                                ok_next     = 1'b1;
                            end
                        end
                        vprf_pkg::KIND_GET, vprf_pkg::KIND_PEEK:
                        begin
                            consume_next  = (vprf_pkg::kind_t'(req.kind) == vprf_pkg::KIND_GET);
                            hdr_only_next = req.header_only;
                            bsize_next    = req.buffer_size;
                        end
                        vprf_pkg::KIND_CLEAR:
                        begin
                            rp_next     = '0;
                            wp_next     = '0;
                            active_next = 1'b0;
                            left_next   = '0;
                            ok_next     = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            vprf_pkg::S_PHDR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = wp_reg + vprf_pkg::PTR_W'(idx_reg);
                ram_wr.data = vprf_pkg::hdr_word(idx_reg, len_reg, seq_reg, user_reg);
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == vprf_pkg::IDX_W'(vprf_pkg::HEADER_WORDS - 1) && left_reg != '0)
                begin
                    active_next = 1'b1;
                end
            end
            vprf_pkg::S_PTAIL:
            begin
                // The tail word closes the packet and makes it visible to readers.
                ram_wr.en   = 1'b1;
                ram_wr.addr = cursor_reg;
                ram_wr.data = '0;
                wp_next     = cursor_reg + 1'b1;
                active_next = 1'b0;
                left_next   = '0;
                if (ring_empty)
                begin
                    head_len_next = push_len_reg;
                end
            end
            vprf_pkg::S_GHDR:
            begin
                // A read issued in one cycle is captured in the next.
                if (idx_reg < vprf_pkg::IDX_W'(vprf_pkg::HDR_READS))
                begin
                    ram_rd.en   = 1'b1;
                    ram_rd.addr = rp_reg + vprf_pkg::PTR_W'(idx_reg);
                end
                if (idx_reg == vprf_pkg::IDX_W'(1))
                begin
                    len_next = ram_rd_data[vprf_pkg::LEN_W-1:0];
                end
                if (idx_reg == vprf_pkg::IDX_W'(2))
                begin
                    seq_next = ram_rd_data;
                end
                for (int u = 0; u < vprf_pkg::USER_WORDS; u++)
                begin
                    if (idx_reg == vprf_pkg::IDX_W'(3 + u))
                    begin
                        user_next[u] = ram_rd_data;
                    end
                end
                idx_next = idx_reg + 1'b1;
            end
            vprf_pkg::S_GCHK:
            begin
                nw_next     = get_nw;
                new_rp_next = new_rp;
                ok_next     = 1'b0;
                show_next   = 1'b0;
                if (!get_fail)
                begin
                    if (consume_reg)
                    begin
                        if (new_rp != wp_reg)
                        begin
                            ram_rd.en   = 1'b1;
                            ram_rd.addr = new_rp;
                        end
                        else
                        begin
                            hl_after_next    = '0;
                            empty_after_next = 1'b1;
                        end
                    end
                    else
                    begin
                        hl_after_next    = len_reg;
                        empty_after_next = 1'b0;
                    end
                end
            end
            vprf_pkg::S_GHL:
            begin
                hl_after_next    = ram_rd_data[vprf_pkg::LEN_W-1:0];
                empty_after_next = 1'b0;
            end
            vprf_pkg::S_GHEAD:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    e_ok    = 1'b1;
                    e_len   = len_reg;
                    e_seq   = seq_reg;
                    e_user  = user_reg;
                    e_last  = head_last;
                    e_hl    = hl_after_reg;
                    e_empty = empty_after_reg;
                    if (head_last)
                    begin
                        if (consume_reg)
                        begin
                            rp_next       = new_rp_reg;
                            head_len_next = hl_after_reg;
                        end
                    end
                    else
                    begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = rp_reg + vprf_pkg::PTR_W'(vprf_pkg::HEADER_WORDS);
                        idx_next    = '0;
                    end
                end
            end
            vprf_pkg::S_GWORD:
            begin
                // Each word taken issues the read of the next, so words stream one per cycle while rsp does not stall.
                if (slot_free)
                begin
                    emit    = 1'b1;
                    e_ok    = 1'b1;
                    e_len   = len_reg;
                    e_seq   = seq_reg;
                    e_user  = user_reg;
                    e_word  = word_last ? (ram_rd_data & vprf_pkg::tail_mask(len_reg[1:0]))
                                        : ram_rd_data;
                    e_last  = word_last;
                    e_hl    = hl_after_reg;
                    e_empty = empty_after_reg;
                    idx_next = idx_reg + 1'b1;
                    if (word_last)
                    begin
                        if (consume_reg)
                        begin
                            rp_next       = new_rp_reg;
                            head_len_next = hl_after_reg;
                        end
                    end
                    else
                    begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = rp_reg + vprf_pkg::PTR_W'(vprf_pkg::HEADER_WORDS)
                                    + vprf_pkg::PTR_W'(idx_reg) + 1'b1;
                    end
                end
            end
            vprf_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    e_ok    = ok_reg;
                    e_len   = show_reg ? len_reg : '0;
                    e_seq   = show_reg ? seq_reg : '0;
                    e_last  = 1'b1;
                    e_hl    = ring_empty ? '0 : head_len_reg;
                    e_empty = ring_empty;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vprf_pkg::S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cursor_reg    <= '0;
            left_reg      <= '0;
            active_reg    <= 1'b0;
            seq_cnt_reg   <= '0;
            head_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            cursor_reg   <= cursor_next;
            left_reg     <= left_next;
            active_reg   <= active_next;
            seq_cnt_reg  <= seq_cnt_next;
            head_len_reg <= head_len_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        push_len_reg    <= push_len_next;
        len_reg         <= len_next;
        seq_reg         <= seq_next;
        user_reg        <= user_next;
        ok_reg          <= ok_next;
        show_reg        <= show_next;
        consume_reg     <= consume_next;
        hdr_only_reg    <= hdr_only_next;
        bsize_reg       <= bsize_next;
        nw_reg          <= nw_next;
        new_rp_reg      <= new_rp_next;
        hl_after_reg    <= hl_after_next;
        empty_after_reg <= empty_after_next;
        idx_reg         <= idx_next;
        if (emit)
        begin
            o_ok_reg    <= e_ok;
            o_len_reg   <= e_len;
            o_seq_reg   <= e_seq;
            o_user_reg  <= e_user;
            o_word_reg  <= e_word;
            o_last_reg  <= e_last;
            o_hl_reg    <= e_hl;
            o_empty_reg <= e_empty;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = o_ok_reg;
    assign rsp.packet_len = o_len_reg;
    assign rsp.seq_number = o_seq_reg;
    assign rsp.out_user1  = o_user_reg[0];
    assign rsp.out_user2  = o_user_reg[1];
    assign rsp.out_user3  = o_user_reg[2];
    assign rsp.out_user4  = o_user_reg[3];
    assign rsp.out_word   = o_word_reg;
    assign rsp.last       = o_last_reg;
    assign rsp.head_len   = o_hl_reg;
    assign rsp.empty_res  = o_empty_reg;

endmodule

@@ sv/vprf_checker.sv @@
// Port-level assertions for the packet ring FIFO and the bind that attaches them.
module vprf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_ok,
    input logic                       rsp_last,
    input logic [vprf_pkg::LEN_W-1:0] rsp_head_len,
    input logic                       rsp_empty
);

    // Requests taken whose final result has not yet left.
    logic [1:0] open_reg;
    logic       req_fire;
    logic       rsp_done;

    assign req_fire = req_valid && req_ready;
    assign rsp_done = rsp_valid && rsp_ready && rsp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + {1'b0, req_fire} - {1'b0, rsp_done};
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    a_rsp_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("result without an outstanding request");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("request taken while another is still being worked on");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty |-> rsp_head_len == '0)
        else $error("empty ring reports a head length");

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_last)
        else $error("failed request produced more than one result");

endmodule

bind variable_packet_ring_fifo vprf_checker u_vprf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_last     (rsp.last),
    .rsp_head_len (rsp.head_len),
    .rsp_empty    (rsp.empty_res)
);
